// File: rtl/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types and constants for the sorted priority queue cell chain.
// ============================================================================
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // broadcast to every cell for one beat
    typedef struct packed {
        logic                     insert;
        logic                     remove;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     ge;     // held entry >= inserted value
        logic signed [DATA_W-1:0] data;
    } t_cell_link;

endpackage

// File: rtl/spq_cell.sv
// ============================================================================
// spq_cell
// One slot of the sorted chain: holds one entry and shifts with its neighbors.
// ============================================================================
module spq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_cell_ctl  i_ctl,
    input  spq_pkg::t_cell_link i_left,
    input  spq_pkg::t_cell_link i_right,
    output spq_pkg::t_cell_link o_link
);
    import spq_pkg::*;

    logic                     r_valid;
    logic                     n_valid;
    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     w_ge;

    assign w_ge = r_valid && (r_data >= i_ctl.value);

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.insert) begin
            // keep if we sort ahead of the new value, else take it or the left entry
            n_valid = r_valid | i_left.valid;
            if (!w_ge) begin
                n_data = i_left.ge ? i_ctl.value : i_left.data;
            end
        end else if (i_ctl.remove) begin
            n_valid = i_right.valid;
            n_data  = i_right.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_link = '{valid: r_valid, ge: w_ge, data: r_data};

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// ============================================================================
// sorted_priority_queue_unit
// Max-priority queue kept sorted in descending order in a chain of cells.
// ============================================================================
//  channel   signals                                   handshake
//  command   start, i_op, i_value                      start && !busy
//  result    o_removed_value, o_removed_valid,         o_done, one cycle
//            o_status, o_entry_count, o_top_value
//
//  One beat per cycle: every cell compares and shifts in parallel, so busy
//  stays low and a command is taken on any cycle.
//  The result appears in the cycle after the command, on registered outputs.
//  Reset clears the cell valid bits and the count; entry data is not reset.
//  The receiver cannot stall; each result shows for exactly one cycle.
// ============================================================================
module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic signed [spq_pkg::DATA_W-1:0] i_value,
    output logic                            o_done,
    output logic signed [spq_pkg::DATA_W-1:0] o_removed_value,
    output logic                            o_removed_valid,
    output logic [1:0]                      o_status,
    output logic [spq_pkg::COUNT_OUT_W-1:0] o_entry_count,
    output logic signed [spq_pkg::DATA_W-1:0] o_top_value
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_cell_ctl  w_ctl;
    t_cell_link w_link  [CAPACITY];
    t_cell_link w_left  [CAPACITY];
    t_cell_link w_right [CAPACITY];

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_ins_ok;
    logic                     w_rem_ok;

    logic                     r_done;
    logic signed [DATA_W-1:0] r_removed_value;
    logic signed [DATA_W-1:0] n_removed_value;
    logic                     r_removed_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [DATA_W-1:0] r_top;
    logic signed [DATA_W-1:0] n_top;

    assign busy    = 1'b0;
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_ins_ok = start && (t_op'(i_op) == OP_INSERT) && !w_full;
    assign w_rem_ok = start && (t_op'(i_op) == OP_REMOVE) && !w_empty;

    assign w_ctl = '{insert: w_ins_ok, remove: w_rem_ok, value: i_value};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                // virtual entry ahead of the head sorts above everything
                assign w_left[gi] = '{valid: 1'b1, ge: 1'b1, data: '0};
            end else begin : g_mid
                assign w_left[gi] = w_link[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign w_right[gi] = '{valid: 1'b0, ge: 1'b0, data: '0};
            end else begin : g_next
                assign w_right[gi] = w_link[gi+1];
            end
            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_left[gi]),
                .i_right (w_right[gi]),
                .o_link  (w_link[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count         = r_count;
        n_status        = ST_OK;
        n_removed_value = '0;
        if (w_ins_ok) begin
            n_count = r_count + 1'b1;
        end else if (w_rem_ok) begin
            n_count         = r_count - 1'b1;
            n_removed_value = w_link[0].data;
        end else if (start) begin
            n_status = (t_op'(i_op) == OP_INSERT) ? ST_FULL : ST_EMPTY;
        end
    end

    // head of the queue after this beat
    always_comb begin
        n_top = w_link[0].valid ? w_link[0].data : '0;
        if (w_ins_ok) begin
            n_top = w_link[0].ge ? w_link[0].data : i_value;
        end else if (w_rem_ok) begin
            n_top = w_link[1].valid ? w_link[1].data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_removed_value <= n_removed_value;
            r_removed_valid <= w_rem_ok;
            r_status        <= n_status;
            r_top           <= n_top;
        end
    end

    assign o_done          = r_done;
    assign o_removed_value = r_removed_value;
    assign o_removed_valid = r_removed_valid;
    assign o_status        = r_status;
    assign o_entry_count   = COUNT_OUT_W'(r_count);
    assign o_top_value     = r_top;

endmodule

// File: rtl/spq_checker.sv
// ============================================================================
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ============================================================================
module spq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_done,
    input logic                            o_removed_valid,
    input logic [1:0]                      o_status,
    input logic [spq_pkg::COUNT_OUT_W-1:0] o_entry_count,
    input logic [spq_pkg::DATA_W-1:0]      o_top_value
);
    import spq_pkg::*;

    // every accepted beat gives exactly one result the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted command produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without a command");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_removed_valid) |-> (o_status == ST_OK))
        else $error("removed entry flagged with error status");

    a_empty_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> (o_entry_count == '0 && o_top_value == '0))
        else $error("empty remove reported held entries");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_removed_valid) |-> ($past(o_entry_count) != '0 || !$past(o_done)))
        else $error("remove reported from a queue seen empty");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_removed_valid (o_removed_valid),
    .o_status        (o_status),
    .o_entry_count   (o_entry_count),
    .o_top_value     (o_top_value)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sorted_priority_queue_unit. A queue of commands feeds a
// clocked driver that idles at random. An internal sorted shadow list
// predicts each result. A clocked monitor checks every o_done beat field
// by field against the oldest prediction. The stimulus starts with a
// directed set: the extremes, duplicates, a remove on empty and an insert
// on full. Random bursts follow, with their insert/remove mix chosen so
// the queue swings between empty and full.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH       = CAPACITY_DEF;
    localparam int RAND_ITEMS  = 1250;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct {
        logic signed [DATA_W-1:0]  removed_value;
        logic                      removed_valid;
        t_status                   status;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic signed [DATA_W-1:0]  top_value;
    } t_pop_result;

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      start   = 1'b0;
    logic                      busy;
    logic                      i_op    = 1'b0;
    logic signed [DATA_W-1:0]  i_value = '0;
    logic                      o_done;
    logic signed [DATA_W-1:0]  o_removed_value;
    logic                      o_removed_valid;
    logic [1:0]                o_status;
    logic [COUNT_OUT_W-1:0]    o_entry_count;
    logic signed [DATA_W-1:0]  o_top_value;

    t_cmd        cmd_queue[$];
    t_pop_result pending_results[$];

    // shadow of the queue contents, largest first
    logic signed [DATA_W-1:0] shadow_entries [DEPTH];
    int shadow_count = 0;

    int errors        = 0;
    int cmds_sent     = 0;
    int results_seen  = 0;
    int inserts_done  = 0;
    int removes_done  = 0;
    int empty_removes = 0;
    int full_drops    = 0;
    int peak_count    = 0;
    int cycle_count   = 0;

    sorted_priority_queue_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_removed_value (o_removed_value),
        .o_removed_valid (o_removed_valid),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_top_value     (o_top_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one command to the shadow list and queue its expected result
    task automatic apply_queue_op(input t_op op, input logic signed [DATA_W-1:0] v);
        t_pop_result r;
        int pos;
        r.removed_value = '0;
        r.removed_valid = 1'b0;
        r.status        = ST_OK;
        if (op == OP_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
                full_drops++;
            end else begin
                pos = shadow_count;
                // ties stay ahead of the new value
                while (pos > 0 && shadow_entries[pos-1] < v) begin
                    shadow_entries[pos] = shadow_entries[pos-1];
                    pos--;
                end
                shadow_entries[pos] = v;
                shadow_count++;
                inserts_done++;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
                empty_removes++;
            end else begin
                r.removed_value = shadow_entries[0];
                r.removed_valid = 1'b1;
                for (int i = 1; i < shadow_count; i++)
                    shadow_entries[i-1] = shadow_entries[i];
                shadow_count--;
                removes_done++;
            end
        end
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        r.entry_count = COUNT_OUT_W'(shadow_count);
        r.top_value   = (shadow_count > 0) ? shadow_entries[0] : '0;
        pending_results.push_back(r);
    endtask

    task automatic add_cmd(input t_op op, input logic signed [DATA_W-1:0] v);
        t_cmd c;
        c.op    = op;
        c.value = v;
        cmd_queue.push_back(c);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $signed($urandom_range(0, 8)) - 4;   // many duplicates
            7:          v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:    v = $signed(32'h8000_0000 + $urandom_range(0, 3)
                                    - $urandom_range(0, 3));
        endcase
        return v;
    endfunction

    task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
                               input logic signed [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: holds a beat until start && !busy is seen at an edge
    always @(posedge i_clk) begin : driver
        t_cmd nxt;
        logic no_idle;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_queue_op(t_op'(i_op), i_value);
                cmds_sent++;
            end
            if (!(start && busy)) begin
                no_idle = (cmds_sent >= 500 && cmds_sent < 800);
                if (cmd_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
                    nxt = cmd_queue.pop_front();
                    start   <= 1'b1;
                    i_op    <= nxt.op;
                    i_value <= nxt.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_pop_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, top %0d count %0d",
                         $time, o_top_value, o_entry_count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("removed_value", want.removed_value, o_removed_value);
                check_field("removed_valid", 32'(want.removed_valid), 32'(o_removed_valid));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("entry_count", 32'(want.entry_count), 32'(o_entry_count));
                check_field("top_value", want.top_value, o_top_value);
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        int bias;
        int burst;

        // remove on empty, value ignored
        add_cmd(OP_REMOVE, 32'shFFFF_FFFF);
        add_cmd(OP_REMOVE, 32'sh0);
        // extremes and duplicates, then fill to capacity
        add_cmd(OP_INSERT, 32'sh7FFF_FFFF);
        add_cmd(OP_INSERT, 32'sh8000_0000);
        add_cmd(OP_INSERT, 32'sh0);
        add_cmd(OP_INSERT, -32'sd1);
        add_cmd(OP_INSERT, 32'sd1);
        add_cmd(OP_INSERT, 32'sh7FFF_FFFF);
        add_cmd(OP_INSERT, 32'sh8000_0000);
        add_cmd(OP_INSERT, 32'sh0);
        add_cmd(OP_INSERT, -32'sd5);
        add_cmd(OP_INSERT, 32'sd5);
        add_cmd(OP_INSERT, 32'sd100);
        add_cmd(OP_INSERT, -32'sd100);
        add_cmd(OP_INSERT, 32'sd2);
        add_cmd(OP_INSERT, -32'sd2);
        add_cmd(OP_INSERT, 32'sd3);
        add_cmd(OP_INSERT, 32'shAAAA_AAAA);
        // insert on full is dropped
        add_cmd(OP_INSERT, 32'sh5555_5555);
        add_cmd(OP_REMOVE, 32'sh5555_5555);
        add_cmd(OP_REMOVE, 32'shAAAA_AAAA);
        add_cmd(OP_REMOVE, 32'sh0);
        add_cmd(OP_INSERT, 32'sd4);
        add_cmd(OP_REMOVE, 32'sh0);

        // random bursts, each with its own insert/remove mix
        n = 0;
        while (n < RAND_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       bias = 15;
                1:       bias = 50;
                default: bias = 85;
            endcase
            burst = $urandom_range(10, 60);
            repeat (burst) begin
                add_cmd(($urandom_range(0, 99) < bias) ? OP_INSERT : OP_REMOVE, rand_value());
                n++;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Ran %0d commands: %0d inserts, %0d removes, %0d removes on empty,",
                 cmds_sent, inserts_done, removes_done, empty_removes);
        $display("%0d inserts dropped on full, peak depth %0d, %0d results checked.",
                 full_drops, peak_count, results_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
